>>> rtl/core/ncse_pkg.sv
`timescale 1ns / 1ps
package ncse_pkg;

  localparam int MAX_KNOTS = 16;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = $clog2(MAX_KNOTS);
  // wide accumulator for the scaled numerator
  localparam int ACC_W     = 144;
  // signed width of the coefficient sum; the multiplier operand below is one bit wider
  localparam int SUM_W     = 32 + IDX_W;
  localparam int MB_W      = SUM_W + 1;
  localparam int MCNT_W    = $clog2(MB_W + 1);
  // magnitude of the numerator after dropping the fraction scale
  localparam int QW        = ACC_W - 2 * FRAC_BITS - 1;
  localparam int DCNT_W    = $clog2(QW + 1);

  localparam logic [1:0] CFG_RANGE_MIN  = 2'd0;
  localparam logic [1:0] CFG_RANGE_MAX  = 2'd1;
  localparam logic [1:0] CFG_KNOT_COUNT = 2'd2;

  localparam logic CMD_EVAL  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic                    start;
    logic [ACC_W-1:0]        a;
    logic [MB_W-1:0]         b;
  } mul_req_t;

  typedef struct packed {
    logic                    start;
    logic [QW-1:0]           dividend;
    logic [31:0]             divisor;
    logic [DCNT_W-1:0]       steps;
  } div_req_t;

endpackage

>>> rtl/core/ncse_cell.sv
`timescale 1ns / 1ps
module ncse_cell (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [31:0] wr_data,
  input  logic        shift,
  input  logic [31:0] nb_data,
  output logic [31:0] data
);

  logic [31:0] data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else if (wr_en) begin
      data_r <= wr_data;
    end else if (shift) begin
      // take the neighbor's coefficient
      data_r <= nb_data;
    end
  end

  assign data = data_r;

endmodule

>>> rtl/core/ncse_mul.sv
`timescale 1ns / 1ps
module ncse_mul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ncse_pkg::mul_req_t             req,
  output logic                           done,
  output logic [ncse_pkg::ACC_W-1:0]     prod
);

  logic [ncse_pkg::ACC_W-1:0]  a_r;
  logic [ncse_pkg::MB_W-1:0]   b_r;
  logic [ncse_pkg::ACC_W-1:0]  p_r;
  logic [ncse_pkg::MCNT_W-1:0] cnt_r;
  logic                        busy_r;
  logic                        done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !req.start && busy_r && (cnt_r == ncse_pkg::MCNT_W'(1));
      if (req.start) begin
        a_r    <= req.a;
        b_r    <= req.b;
        p_r    <= '0;
        cnt_r  <= ncse_pkg::MCNT_W'(ncse_pkg::MB_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // sign bit of the multiplier carries negative weight
        if (b_r[0]) begin
          p_r <= (cnt_r == ncse_pkg::MCNT_W'(1)) ? p_r - a_r : p_r + a_r;
        end
        a_r   <= {a_r[ncse_pkg::ACC_W-2:0], 1'b0};
        b_r   <= {b_r[ncse_pkg::MB_W-1], b_r[ncse_pkg::MB_W-1:1]};
        cnt_r <= cnt_r - ncse_pkg::MCNT_W'(1);
        if (cnt_r == ncse_pkg::MCNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

>>> rtl/core/ncse_div.sv
`timescale 1ns / 1ps
module ncse_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ncse_pkg::div_req_t         req,
  output logic                       done,
  output logic [ncse_pkg::QW-1:0]    quot,
  output logic [31:0]                rem
);

  logic [31:0]                 rem_r;
  logic [ncse_pkg::QW-1:0]     dq_r;
  logic [31:0]                 dv_r;
  logic [ncse_pkg::DCNT_W-1:0] cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [32:0]                 rem_sh;
  logic                        ge;
  logic [32:0]                 rem_sub;

  assign rem_sh  = {rem_r, dq_r[ncse_pkg::QW-1]};
  assign ge      = rem_sh >= {1'b0, dv_r};
  assign rem_sub = rem_sh - {1'b0, dv_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !req.start && busy_r && (cnt_r == ncse_pkg::DCNT_W'(1));
      if (req.start) begin
        rem_r  <= '0;
        dq_r   <= req.dividend;
        dv_r   <= req.divisor;
        cnt_r  <= req.steps;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? rem_sub[31:0] : rem_sh[31:0];
        dq_r  <= {dq_r[ncse_pkg::QW-2:0], ge};
        cnt_r <= cnt_r - ncse_pkg::DCNT_W'(1);
        if (cnt_r == ncse_pkg::DCNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = dq_r;
  assign rem  = rem_r;

endmodule

>>> rtl/core/natural_cubic_spline_evaluator.sv
`timescale 1ns / 1ps
// Evaluates a natural cubic spline in truncated power form on signed Q16.16 data. A write
// word stores one coefficient; an evaluate word returns one result. With no coefficient
// written or a knot count below two the result is zero and goes straight to the output
// state. Otherwise, for K knots, the evaluation runs a 32-step divide for the knot spacing,
// three multiplies for the constant and linear parts, three bit-serial multiplies per
// knot term through one shared shift-add multiplier, and a 111-step divide of the numerator
// by the knot spacing. An empty or reversed range skips the knot terms and the spacing
// divide; a range narrower than K+1 raw units skips the knot terms.
// Coefficients sit in a ring of cells that rotates one place per term, so the current
// coefficient is always at the head cell. The block takes one word at a time and accepts the
// next word once the result is loaded; a finished result waits in the output register while
// the next word is accepted.
module natural_cubic_spline_evaluator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // coeff_index[3:0], coeff_value[35:4], x_value[67:36]
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // y_value[31:0]
  output logic        out_tuser,  // saturated
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int ACC_W = ncse_pkg::ACC_W;
  localparam int MB_W  = ncse_pkg::MB_W;
  localparam int SUM_W = ncse_pkg::SUM_W;
  localparam int QW    = ncse_pkg::QW;
  localparam int F2    = 2 * ncse_pkg::FRAC_BITS;
  localparam int NK    = ncse_pkg::MAX_KNOTS;
  localparam int IDX_W = ncse_pkg::IDX_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DIVH, S_PREP, S_C0H_W, S_C1X, S_C1X_W, S_C1XH_W,
    S_KNOT, S_SQ_W, S_CUBE_W, S_TERM_W, S_QGO, S_QDIV, S_OUT
  } state_t;

  state_t              state_r;
  logic signed [31:0]  mn_r, mx_r, x_r;
  logic [4:0]          kcfg_r, keff_r, j_r;
  logic                present_r, dpos_r, narrow_r, neg_r;
  logic [31:0]         h_r, off_r, p_r;
  logic [4:0]          rd_r;
  logic [5:0]          rr_r;
  logic signed [SUM_W-1:0] s_r;
  logic [ACC_W-1:0]    sum_r;
  logic [IDX_W-1:0]    rot_r;
  logic [31:0]         res_y_r, out_y_r;
  logic                res_sat_r, out_sat_r, out_valid_r;

  logic [3:0]          coeff_index;
  logic [31:0]         coeff_value, x_value;
  logic                in_fire, wr_fire, zero_path;
  logic [4:0]          keff_cfg, kp1_cfg;
  logic signed [32:0]  d_s;
  logic                d_pos;
  logic [31:0]         head, h_eff;
  logic signed [31:0]  x_cl;
  logic signed [32:0]  t_s;
  logic signed [33:0]  diff;
  logic [31:0]         p_now;
  logic [5:0]          rsum, kp1_6, rr_nxt;
  logic                cy, last;
  logic [31:0]         off_nxt;
  logic [QW-1:0]       mag;
  logic                sat_now;
  logic [31:0]         y_now;
  logic                shift_en;

  ncse_pkg::mul_req_t  mul_req;
  ncse_pkg::div_req_t  div_req;
  logic                mul_done, div_done;
  logic [ACC_W-1:0]    mul_prod;
  logic [QW-1:0]       div_quot;
  logic [31:0]         div_rem;

  logic [31:0] cell_q [NK];

  assign coeff_index = in_tdata[3:0];
  assign coeff_value = in_tdata[35:4];
  assign x_value     = in_tdata[67:36];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign wr_fire   = in_fire && (in_tuser == ncse_pkg::CMD_WRITE) &&
                     ({1'b0, coeff_index} < 5'(NK));
  assign zero_path = !present_r || (kcfg_r < 5'd2);

  assign keff_cfg = (kcfg_r > 5'(NK)) ? 5'(NK) : kcfg_r;
  assign kp1_cfg  = keff_cfg + 5'd1;
  assign d_s      = {mx_r[31], mx_r} - {mn_r[31], mn_r};
  assign d_pos    = !d_s[32] && (d_s != '0);

  assign head  = cell_q[0];
  assign h_eff = (!dpos_r || (h_r == '0)) ? 32'd1 : h_r;
  assign x_cl  = (x_r < mn_r) ? mn_r : ((x_r > mx_r) ? mx_r : x_r);

  // truncated power term at the current knot
  assign t_s   = {mn_r[31], mn_r} + {1'b0, off_r};
  assign diff  = {x_r[31], x_r[31], x_r} - {t_s[32], t_s};
  assign p_now = (!diff[33] && (diff != '0)) ? diff[31:0] : '0;

  // advance knot offset: floor(j*D/(K+1)) from h and D mod (K+1)
  assign rsum    = rr_r + {1'b0, rd_r};
  assign kp1_6   = {1'b0, keff_r} + 6'd1;
  assign cy      = rsum >= kp1_6;
  assign rr_nxt  = cy ? rsum - kp1_6 : rsum;
  assign off_nxt = off_r + h_r + {31'b0, cy};
  assign last    = (j_r == keff_r - 5'd1);

  // floor division of a negative numerator divides its complement
  assign mag     = sum_r[ACC_W-1] ? ~sum_r[ACC_W-2:F2] : sum_r[ACC_W-2:F2];
  assign sat_now = |div_quot[QW-1:31];
  assign y_now   = sat_now ? (neg_r ? 32'h8000_0000 : 32'h7fff_ffff)
                           : (neg_r ? ~div_quot[31:0] : div_quot[31:0]);

  assign shift_en = ((state_r == S_C0H_W) && mul_done) ||
                    ((state_r == S_C1XH_W) && mul_done) ||
                    ((state_r == S_TERM_W) && mul_done && !last) ||
                    (((state_r == S_QGO) || (state_r == S_QDIV)) && (rot_r != '0));

  for (genvar i = 0; i < NK; i++) begin : g_ring
    ncse_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (wr_fire && (coeff_index == IDX_W'(i))),
      .wr_data (coeff_value),
      .shift   (shift_en),
      .nb_data (cell_q[(i + 1) % NK]),
      .data    (cell_q[i])
    );
  end

  always_comb begin
    mul_req = '0;
    unique case (state_r)
      S_PREP: begin
        mul_req.start = 1'b1;
        mul_req.a     = {{(ACC_W-32){head[31]}}, head};
        mul_req.b     = {{(MB_W-32){1'b0}}, h_eff};
      end
      S_C1X: begin
        mul_req.start = 1'b1;
        mul_req.a     = {{(ACC_W-32){head[31]}}, head};
        mul_req.b     = {{(MB_W-32){x_r[31]}}, x_r};
      end
      S_C1X_W: begin
        mul_req.start = mul_done;
        mul_req.a     = mul_prod;
        mul_req.b     = {{(MB_W-32){1'b0}}, h_r};
      end
      S_KNOT: begin
        mul_req.start = 1'b1;
        mul_req.a     = {{(ACC_W-32){1'b0}}, p_now};
        mul_req.b     = {{(MB_W-32){1'b0}}, p_now};
      end
      S_SQ_W: begin
        mul_req.start = mul_done;
        mul_req.a     = mul_prod;
        mul_req.b     = {{(MB_W-32){1'b0}}, p_r};
      end
      S_CUBE_W: begin
        mul_req.start = mul_done;
        mul_req.a     = mul_prod;
        mul_req.b     = last ? {{(MB_W-SUM_W){s_r[SUM_W-1]}}, s_r}
                             : {{(MB_W-32){head[31]}}, head};
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  always_comb begin
    div_req = '0;
    if ((state_r == S_IDLE) && in_fire && (in_tuser == ncse_pkg::CMD_EVAL) &&
        !zero_path && d_pos) begin
      div_req.start    = 1'b1;
      div_req.dividend = {d_s[31:0], {(QW-32){1'b0}}};
      div_req.divisor  = {27'b0, kp1_cfg};
      div_req.steps    = ncse_pkg::DCNT_W'(32);
    end else if (state_r == S_QGO) begin
      div_req.start    = 1'b1;
      div_req.dividend = mag;
      div_req.divisor  = h_r;
      div_req.steps    = ncse_pkg::DCNT_W'(QW);
    end
  end

  ncse_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  ncse_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mn_r   <= '0;
      mx_r   <= 32'sd65536;
      kcfg_r <= 5'd2;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ncse_pkg::CFG_RANGE_MIN:  mn_r   <= cfg_wdata;
        ncse_pkg::CFG_RANGE_MAX:  mx_r   <= cfg_wdata;
        ncse_pkg::CFG_KNOT_COUNT: kcfg_r <= cfg_wdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      present_r   <= 1'b0;
      rot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_OUT) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (shift_en) begin
        rot_r <= (rot_r == IDX_W'(NK - 1)) ? '0 : rot_r + IDX_W'(1);
      end
      unique case (state_r)
        S_IDLE: begin
          if (wr_fire) begin
            present_r <= 1'b1;
          end
          if (in_fire && (in_tuser == ncse_pkg::CMD_EVAL)) begin
            x_r    <= x_value;
            keff_r <= keff_cfg;
            dpos_r <= d_pos;
            if (zero_path) begin
              res_y_r   <= '0;
              res_sat_r <= 1'b0;
              state_r   <= S_OUT;
            end else if (d_pos) begin
              state_r <= S_DIVH;
            end else begin
              state_r <= S_PREP;
            end
          end
        end
        S_DIVH: begin
          if (div_done) begin
            h_r     <= div_quot[31:0];
            rd_r    <= div_rem[4:0];
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          narrow_r <= !dpos_r || (h_r == '0);
          h_r      <= h_eff;
          // collapse onto range_min, then clamp to range_max
          x_r      <= (!dpos_r || (h_r == '0)) ? ((mn_r > mx_r) ? mx_r : mn_r) : x_cl;
          state_r  <= S_C0H_W;
        end
        S_C0H_W: begin
          if (mul_done) begin
            sum_r   <= {mul_prod[ACC_W-F2-1:0], {F2{1'b0}}};
            state_r <= S_C1X;
          end
        end
        S_C1X: begin
          state_r <= S_C1X_W;
        end
        S_C1X_W: begin
          if (mul_done) begin
            state_r <= S_C1XH_W;
          end
        end
        S_C1XH_W: begin
          if (mul_done) begin
            sum_r <= sum_r + {mul_prod[ACC_W-F2/2-1:0], {(F2/2){1'b0}}};
            if (narrow_r) begin
              state_r <= S_QGO;
            end else begin
              off_r   <= h_r;
              rr_r    <= {1'b0, rd_r};
              j_r     <= 5'd1;
              s_r     <= '0;
              state_r <= S_KNOT;
            end
          end
        end
        S_KNOT: begin
          p_r     <= p_now;
          state_r <= S_SQ_W;
        end
        S_SQ_W: begin
          if (mul_done) begin
            state_r <= S_CUBE_W;
          end
        end
        S_CUBE_W: begin
          if (mul_done) begin
            if (!last) begin
              s_r <= s_r + {{(SUM_W-32){head[31]}}, head};
            end
            state_r <= S_TERM_W;
          end
        end
        S_TERM_W: begin
          if (mul_done) begin
            if (last) begin
              sum_r   <= sum_r - mul_prod;
              state_r <= S_QGO;
            end else begin
              sum_r   <= sum_r + mul_prod;
              j_r     <= j_r + 5'd1;
              off_r   <= off_nxt;
              rr_r    <= rr_nxt;
              state_r <= S_KNOT;
            end
          end
        end
        S_QGO: begin
          neg_r   <= sum_r[ACC_W-1];
          state_r <= S_QDIV;
        end
        S_QDIV: begin
          if (div_done) begin
            res_y_r   <= y_now;
            res_sat_r <= sat_now;
            state_r   <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_r || out_tready) begin
            out_y_r     <= res_y_r;
            out_sat_r   <= res_sat_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_y_r;
  assign out_tuser  = out_sat_r;

  a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> rot_r == '0)
    else $error("coefficient ring not aligned while idle");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 32'h7fff_ffff || out_tdata == 32'h8000_0000)
    else $error("saturated word without a limit value");

  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == S_C0H_W || state_r == S_C1X_W || state_r == S_C1XH_W ||
                 state_r == S_SQ_W || state_r == S_CUBE_W || state_r == S_TERM_W)
    else $error("multiplier finished outside a wait state");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIVH || state_r == S_QDIV)
    else $error("divider finished outside a wait state");

endmodule
